[rtl/grid_region_marker_defines.svh]
// assertion macros for the grid region marker
`ifndef GRID_REGION_MARKER_DEFINES_SVH
`define GRID_REGION_MARKER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define GRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define GRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/grm_pkg.sv]
// shared types and codes of the grid region marker
`timescale 1ns / 1ps
`default_nettype none

package grm_pkg;

    localparam int COORD_W   = 12;
    localparam int CELL_W    = 16;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 4 * COORD_W + CELL_W;
    localparam int M_DATA_W  = CELL_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COORD_W:0]   lim_t;
    typedef logic signed [COORD_W+1:0] dlt_t;
    typedef logic signed [COORD_W+2:0] err_t;
    typedef logic signed [COORD_W+3:0] e2_t;
    typedef logic signed [CELL_W-1:0]  cell_t;
    typedef logic signed [CELL_W:0]    cell_sum_t;

    localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_POINT = 3'd2;
    localparam logic [OP_W-1:0] OP_LINE  = 3'd3;
    localparam logic [OP_W-1:0] OP_RECT  = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;

    localparam logic [CFG_W-1:0] CFG_COLS_RST = 7'd64;
    localparam logic [CFG_W-1:0] CFG_ROWS_RST = 7'd64;

    localparam cell_t MARK_STEP = 16'sd512;
    localparam cell_t CELL_MAX  = 16'sh7fff;

endpackage

`default_nettype wire

[rtl/grid_region_marker.sv]
// grid region marker: cell store with write, read, point, line and rectangle marking
// each in-grid cell of a point, line or clamped rectangle is read, then written back; off-grid
// cells of a line are stepped over; one item at a time, the next transaction is accepted only
// once the result of the last one has been loaded into the output register
// reset: a clearing pass writes zero to all 2**(clog2(GRID_WIDTH)+clog2(GRID_HEIGHT)) cell memory
// entries (4096 by default), one entry a cycle, before s_tready rises
`timescale 1ns / 1ps
`default_nettype none
`include "grid_region_marker_defines.svh"

module grid_region_marker #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [grm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [grm_pkg::CFG_W-1:0]      cfg_wdata,
    // input channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36], write_value[63:48]
    input  wire logic [grm_pkg::S_DATA_W-1:0]   s_tdata,
    // operation[2:0]
    input  wire logic [grm_pkg::OP_W-1:0]       s_tuser,
    input  wire logic                           s_tlast,
    // result channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // cell_value_out[15:0]
    output logic [grm_pkg::M_DATA_W-1:0]        m_tdata,
    // status[1:0]
    output logic [grm_pkg::STAT_W-1:0]          m_tuser,
    output logic                                m_tlast
);

    import grm_pkg::*;

    localparam int XW        = $clog2(GRID_WIDTH);
    localparam int YW        = $clog2(GRID_HEIGHT);
    localparam int AW        = XW + YW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam lim_t GW_L    = lim_t'(GRID_WIDTH);
    localparam lim_t GH_L    = lim_t'(GRID_HEIGHT);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [CFG_W-1:0]    cols_reg;
    logic [CFG_W-1:0]    rows_reg;

    logic [OP_W-1:0]     op_reg;
    coord_t              in_sx_reg;
    coord_t              in_sy_reg;
    coord_t              in_ex_reg;
    coord_t              in_ey_reg;
    cell_t               in_wv_reg;
    logic                in_last_reg;

    coord_t              cur_x_reg;
    coord_t              cur_y_reg;
    coord_t              end_x_reg;
    coord_t              end_y_reg;
    coord_t              rect_y0_reg;
    logic                rect_mode_reg;
    dlt_t                dx_reg;
    dlt_t                dy_reg;
    logic                stx_pos_reg;
    logic                sty_pos_reg;
    err_t                err_reg;

    cell_t               res_value_reg;
    logic [STAT_W-1:0]   res_status_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [STAT_W-1:0]   m_tuser_reg;
    logic                m_tlast_reg;

    cell_t               mem [MEM_DEPTH];
    cell_t               rd_data_reg;
    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    cell_t               mem_wdata;

    lim_t                cols_lim;
    lim_t                rows_lim;
    logic                start_inside;
    logic                pt_inside;
    cell_sum_t           mark_sum;
    cell_t               mark_value;

    coord_t              ex_eff;
    coord_t              ey_eff;
    dlt_t                ddx;
    dlt_t                ddy;
    dlt_t                adx;
    dlt_t                ady;
    lim_t                x0c;
    lim_t                y0c;
    lim_t                x1c;
    lim_t                y1c;
    logic                rect_empty;

    logic                at_end;
    e2_t                 e2;
    coord_t              step_x;
    coord_t              step_y;
    err_t                step_err;

    function automatic logic cell_in(coord_t x, coord_t y, lim_t xl, lim_t yl);
        return !x[COORD_W-1] && !y[COORD_W-1] && (lim_t'(x) < xl) && (lim_t'(y) < yl);
    endfunction

    function automatic logic [AW-1:0] cell_addr(coord_t x, coord_t y);
        return {x[XW-1:0], y[YW-1:0]};
    endfunction

    // active grid size is the smaller of register and storage size
    assign cols_lim = (lim_t'(cols_reg) < GW_L) ? lim_t'(cols_reg) : GW_L;
    assign rows_lim = (lim_t'(rows_reg) < GH_L) ? lim_t'(rows_reg) : GH_L;

    assign start_inside = cell_in(in_sx_reg, in_sy_reg, cols_lim, rows_lim);
    assign pt_inside    = cell_in(cur_x_reg, cur_y_reg, cols_lim, rows_lim);

    // shared saturating add of the mark step
    assign mark_sum   = cell_sum_t'(rd_data_reg) + cell_sum_t'(MARK_STEP);
    assign mark_value = (mark_sum > cell_sum_t'(CELL_MAX)) ? CELL_MAX : mark_sum[CELL_W-1:0];

    // line setup; a point is a line of one cell
    always_comb begin
        ex_eff = (op_reg == OP_POINT) ? in_sx_reg : in_ex_reg;
        ey_eff = (op_reg == OP_POINT) ? in_sy_reg : in_ey_reg;
        ddx    = dlt_t'(ex_eff) - dlt_t'(in_sx_reg);
        ddy    = dlt_t'(ey_eff) - dlt_t'(in_sy_reg);
        adx    = (ddx < 0) ? -ddx : ddx;
        ady    = (ddy < 0) ? -ddy : ddy;
    end

    // rectangle clamped to the active grid
    always_comb begin
        x0c        = in_sx_reg[COORD_W-1] ? '0 : lim_t'(in_sx_reg);
        y0c        = in_sy_reg[COORD_W-1] ? '0 : lim_t'(in_sy_reg);
        x1c        = (lim_t'(in_ex_reg) > cols_lim - lim_t'(1)) ? cols_lim - lim_t'(1)
                                                                 : lim_t'(in_ex_reg);
        y1c        = (lim_t'(in_ey_reg) > rows_lim - lim_t'(1)) ? rows_lim - lim_t'(1)
                                                                 : lim_t'(in_ey_reg);
        rect_empty = (x0c > x1c) || (y0c > y1c);
    end

    // next cell of the walk, bresenham step or column-by-column order for a rectangle
    always_comb begin
        at_end   = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
        e2       = e2_t'(err_reg) <<< 1;
        step_x   = cur_x_reg;
        step_y   = cur_y_reg;
        step_err = err_reg;
        if (rect_mode_reg) begin
            if (cur_y_reg == end_y_reg) begin
                step_y = rect_y0_reg;
                step_x = cur_x_reg + coord_t'(1);
            end else begin
                step_y = cur_y_reg + coord_t'(1);
            end
        end else begin
            if (e2 >= e2_t'(dy_reg)) begin
                step_err = step_err + err_t'(dy_reg);
                step_x   = cur_x_reg + (stx_pos_reg ? coord_t'(1) : coord_t'(-1));
            end
            if (e2 <= e2_t'(dx_reg)) begin
                step_err = step_err + err_t'(dx_reg);
                step_y   = cur_y_reg + (sty_pos_reg ? coord_t'(1) : coord_t'(-1));
            end
        end
    end

    // memory port control
    always_comb begin
        mem_addr  = cell_addr(cur_x_reg, cur_y_reg);
        mem_we    = 1'b0;
        mem_wdata = mark_value;
        unique case (state_reg)
            S_CLEAR: begin
                mem_addr  = clr_addr_reg;
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            S_EXEC: begin
                mem_addr  = cell_addr(in_sx_reg, in_sy_reg);
                mem_we    = (op_reg == OP_WRITE) && start_inside;
                mem_wdata = in_wv_reg;
            end
            S_MARK_WR: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            cols_reg      <= CFG_COLS_RST;
            rows_reg      <= CFG_ROWS_RST;
            m_tvalid_reg  <= 1'b0;
            rect_mode_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_COLS: cols_reg <= cfg_wdata;
                    CFG_ROWS: rows_reg <= cfg_wdata;
                    default:  ;
                endcase
            end

            // the final state loads the next result itself
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (&clr_addr_reg) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg      <= s_tuser;
                        in_sx_reg   <= s_tdata[11:0];
                        in_sy_reg   <= s_tdata[23:12];
                        in_ex_reg   <= s_tdata[35:24];
                        in_ey_reg   <= s_tdata[47:36];
                        in_wv_reg   <= s_tdata[63:48];
                        in_last_reg <= s_tlast;
                        state_reg   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    res_value_reg <= '0;
                    unique case (op_reg)
                        OP_WRITE: begin
                            res_status_reg <= start_inside ? ST_DONE : ST_OUTSIDE;
                            state_reg      <= S_DONE;
                        end
                        OP_READ: begin
                            if (start_inside) begin
                                res_status_reg <= ST_DONE;
                                state_reg      <= S_RDWAIT;
                            end else begin
                                res_status_reg <= ST_OUTSIDE;
                                state_reg      <= S_DONE;
                            end
                        end
                        OP_POINT, OP_LINE: begin
                            res_status_reg <= ST_DONE;
                            rect_mode_reg  <= 1'b0;
                            cur_x_reg      <= in_sx_reg;
                            cur_y_reg      <= in_sy_reg;
                            end_x_reg      <= ex_eff;
                            end_y_reg      <= ey_eff;
                            dx_reg         <= adx;
                            dy_reg         <= -ady;
                            stx_pos_reg    <= (in_sx_reg < ex_eff);
                            sty_pos_reg    <= (in_sy_reg < ey_eff);
                            err_reg        <= err_t'(adx) - err_t'(ady);
                            state_reg      <= S_MARK_RD;
                        end
                        OP_RECT: begin
                            res_status_reg <= ST_DONE;
                            rect_mode_reg  <= 1'b1;
                            cur_x_reg      <= x0c[COORD_W-1:0];
                            cur_y_reg      <= y0c[COORD_W-1:0];
                            rect_y0_reg    <= y0c[COORD_W-1:0];
                            end_x_reg      <= x1c[COORD_W-1:0];
                            end_y_reg      <= y1c[COORD_W-1:0];
                            state_reg      <= rect_empty ? S_DONE : S_MARK_RD;
                        end
                        default: begin
                            res_status_reg <= ST_UNKNOWN;
                            state_reg      <= S_DONE;
                        end
                    endcase
                end
                S_RDWAIT: begin
                    res_value_reg <= rd_data_reg;
                    state_reg     <= S_DONE;
                end
                S_MARK_RD: begin
                    // off-grid cells of a line are stepped over without a memory access
                    if (pt_inside) begin
                        state_reg <= S_MARK_WR;
                    end else if (at_end) begin
                        state_reg <= S_DONE;
                    end else begin
                        cur_x_reg <= step_x;
                        cur_y_reg <= step_y;
                        err_reg   <= step_err;
                    end
                end
                S_MARK_WR: begin
                    if (at_end) begin
                        state_reg <= S_DONE;
                    end else begin
                        cur_x_reg <= step_x;
                        cur_y_reg <= step_y;
                        err_reg   <= step_err;
                        state_reg <= S_MARK_RD;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_value_reg;
                        m_tuser_reg  <= res_status_reg;
                        m_tlast_reg  <= in_last_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `GRM_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second transaction accepted while busy")
    `GRM_ASSERT_NOW(a_rect_inside, aclk, aresetn, (state_reg == S_MARK_RD) && rect_mode_reg, pt_inside, "rectangle walk left the active grid")
    `GRM_ASSERT_NOW(a_mark_grows, aclk, aresetn, state_reg == S_MARK_WR, mem_we && (mem_wdata >= rd_data_reg), "mark write does not raise the cell")
    `GRM_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid, (m_tuser == ST_DONE) || (m_tuser == ST_UNKNOWN) || (m_tuser == ST_OUTSIDE), "bad status code")
    `GRM_ASSERT_NOW(a_value_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_DONE), m_tdata == '0, "nonzero value with error status")

endmodule

`default_nettype wire
